[rtl/cnmt_pkg.sv]
package cnmt_pkg;

  // Field widths
  localparam int unsigned ModeW     = 2;
  localparam int unsigned FrameLenW = 4;
  localparam int unsigned CmdW      = 8;
  localparam int unsigned TargetW   = 8;
  localparam int unsigned NodeIdW   = 7;
  localparam int unsigned StateW    = 3;
  localparam int unsigned CanIdW    = 11;

  // APB port
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  // Register indexes
  localparam logic RegNodeId = 1'b0;

  // Event kinds
  localparam logic [ModeW-1:0] ModePowerOn = 2'd0;
  localparam logic [ModeW-1:0] ModeFrame   = 2'd1;
  localparam logic [ModeW-1:0] ModeLocal   = 2'd2;
  localparam logic [ModeW-1:0] ModeTxDone  = 2'd3;

  // Node states
  localparam logic [StateW-1:0] StOff   = 3'd0;
  localparam logic [StateW-1:0] StWait  = 3'd1;
  localparam logic [StateW-1:0] StPreop = 3'd2;
  localparam logic [StateW-1:0] StOper  = 3'd3;
  localparam logic [StateW-1:0] StStop  = 3'd4;

  // Command specifiers
  localparam logic [CmdW-1:0] CmdStart   = 8'd1;
  localparam logic [CmdW-1:0] CmdStop    = 8'd2;
  localparam logic [CmdW-1:0] CmdPreop   = 8'd128;
  localparam logic [CmdW-1:0] CmdRstNode = 8'd129;
  localparam logic [CmdW-1:0] CmdRstComm = 8'd130;

  // Frame filter and boot-up identifier
  localparam logic [FrameLenW-1:0] FrameLenOk = 4'd2;
  localparam logic [TargetW-1:0]   AddrAll    = 8'd0;
  localparam logic [CanIdW-1:0]    BootUpBase = 11'h700;
  localparam logic [NodeIdW-1:0]   NodeIdRst  = 7'd1;

  // One event as it sits in the input register
  typedef struct packed {
    logic [ModeW-1:0]     mode;
    logic [FrameLenW-1:0] frame_length;
    logic [CmdW-1:0]      command;
    logic [TargetW-1:0]   target_node;
    logic                 tx_failed;
  } evt_t;

  // Input stage to compute stage hand-off
  typedef struct packed {
    logic valid;
    evt_t evt;
  } evt_stage_t;

endpackage

[rtl/cnmt_if.sv]
// Event channel
interface cnmt_evt_if;
  import cnmt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ModeW-1:0]     mode;
  logic [FrameLenW-1:0] frame_length;
  logic [CmdW-1:0]      command;
  logic [TargetW-1:0]   target_node;
  logic                 tx_failed;

  modport source (
    output valid, mode, frame_length, command, target_node, tx_failed,
    input  ready
  );
  modport sink (
    input  valid, mode, frame_length, command, target_node, tx_failed,
    output ready
  );
endinterface

// Result channel
interface cnmt_res_if;
  import cnmt_pkg::*;

  logic              valid;
  logic              ready;
  logic [StateW-1:0] node_state;
  logic              send_boot_up;
  logic [CanIdW-1:0] boot_up_id;
  logic              passed_reset_application;
  logic              passed_reset_communication;
  logic              handled;

  modport source (
    output valid, node_state, send_boot_up, boot_up_id,
           passed_reset_application, passed_reset_communication, handled,
    input  ready
  );
  modport sink (
    input  valid, node_state, send_boot_up, boot_up_id,
           passed_reset_application, passed_reset_communication, handled,
    output ready
  );
endinterface

[rtl/cnmt_apb_regs.sv]
module cnmt_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cnmt_pkg::ApbAddrW-1:0] paddr,
  input  logic [cnmt_pkg::ApbDataW-1:0] pwdata,
  output logic [cnmt_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  output logic [cnmt_pkg::NodeIdW-1:0]  node_id_o
);
  import cnmt_pkg::*;

  logic [NodeIdW-1:0] node_id_q, node_id_d;
  logic               wr_en;
  logic               reg_sel;

  // Word index of the addressed register
  assign reg_sel = paddr[ApbAddrW-1];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Node ID write
  always_comb begin
    node_id_d = node_id_q;
    if (wr_en && reg_sel == RegNodeId) begin
      node_id_d = pwdata[NodeIdW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q <= NodeIdRst;
    end else begin
      node_id_q <= node_id_d;
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      RegNodeId: prdata = {{(ApbDataW-NodeIdW){1'b0}}, node_id_q};
      default:   prdata = '0;
    endcase
  end

  assign node_id_o = node_id_q;

endmodule

[rtl/cnmt_in_stage.sv]
module cnmt_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cnmt_evt_if.sink             evt_i,
  input  logic                 take_i,
  output cnmt_pkg::evt_stage_t stage_o
);
  import cnmt_pkg::*;

  logic valid_q, valid_d;
  evt_t evt_q;
  logic load;

  // Register is free when empty or when its event moves on this cycle
  assign evt_i.ready = ~valid_q | take_i;
  assign load        = evt_i.valid & evt_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      evt_q.mode         <= evt_i.mode;
      evt_q.frame_length <= evt_i.frame_length;
      evt_q.command      <= evt_i.command;
      evt_q.target_node  <= evt_i.target_node;
      evt_q.tx_failed    <= evt_i.tx_failed;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.evt   = evt_q;

endmodule

[rtl/cnmt_core.sv]
module cnmt_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cnmt_pkg::evt_stage_t         stage_i,
  input  logic [cnmt_pkg::NodeIdW-1:0] node_id_i,
  output logic                         take_o,
  cnmt_res_if.source                   res_o
);
  import cnmt_pkg::*;

  logic [StateW-1:0] state_q, state_d;
  logic              out_valid_q, out_valid_d;

  logic [StateW-1:0] res_state_q;
  logic              res_send_q, res_app_q, res_comm_q, res_handled_q;
  logic [CanIdW-1:0] res_id_q;

  logic [StateW-1:0] next;
  logic              send, pass_app, pass_comm, handled;
  logic              active, accept;
  logic [CanIdW-1:0] boot_id;
  evt_t              evt;

  assign evt = stage_i.evt;

  // Event moves to the result register when that is empty or drained
  assign take_o = stage_i.valid & (~out_valid_q | res_o.ready);

  assign active = (state_q == StWait) || (state_q == StPreop) ||
                  (state_q == StOper) || (state_q == StStop);

  // Frame filter: length 2, broadcast or own node
  always_comb begin
    accept = 1'b1;
    if (evt.mode == ModeFrame) begin
      if (evt.frame_length != FrameLenOk) begin
        accept = 1'b0;
      end
      if (evt.target_node != AddrAll &&
          evt.target_node != {{(TargetW-NodeIdW){1'b0}}, node_id_i}) begin
        accept = 1'b0;
      end
    end
  end

  // Next state and result flags
  always_comb begin
    next      = state_q;
    send      = 1'b0;
    pass_app  = 1'b0;
    pass_comm = 1'b0;
    handled   = 1'b0;
    unique case (evt.mode)
      ModePowerOn: begin
        next      = StWait;
        send      = 1'b1;
        pass_app  = 1'b1;
        pass_comm = 1'b1;
        handled   = 1'b1;
      end
      ModeTxDone: begin
        if (state_q == StWait && !evt.tx_failed) begin
          next    = StPreop;
          handled = 1'b1;
        end
      end
      ModeFrame, ModeLocal: begin
        if (active && accept) begin
          unique case (evt.command)
            CmdRstNode: begin
              next      = StWait;
              send      = 1'b1;
              pass_app  = 1'b1;
              pass_comm = 1'b1;
              handled   = 1'b1;
            end
            CmdRstComm: begin
              next      = StWait;
              send      = 1'b1;
              pass_comm = 1'b1;
              handled   = 1'b1;
            end
            CmdStart: begin
              if (state_q == StPreop || state_q == StStop) begin
                next    = StOper;
                handled = 1'b1;
              end
            end
            CmdStop: begin
              if (state_q == StPreop || state_q == StOper) begin
                next    = StStop;
                handled = 1'b1;
              end
            end
            CmdPreop: begin
              if (state_q == StOper || state_q == StStop) begin
                next    = StPreop;
                handled = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Boot-up CAN identifier
  assign boot_id = send ? (BootUpBase + {{(CanIdW-NodeIdW){1'b0}}, node_id_i})
                        : '0;

  // State and output valid
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (take_o) begin
      state_d     = next;
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StOff;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_state_q   <= next;
      res_send_q    <= send;
      res_id_q      <= boot_id;
      res_app_q     <= pass_app;
      res_comm_q    <= pass_comm;
      res_handled_q <= handled;
    end
  end

  assign res_o.valid                      = out_valid_q;
  assign res_o.node_state                 = res_state_q;
  assign res_o.send_boot_up               = res_send_q;
  assign res_o.boot_up_id                 = res_id_q;
  assign res_o.passed_reset_application   = res_app_q;
  assign res_o.passed_reset_communication = res_comm_q;
  assign res_o.handled                    = res_handled_q;

endmodule

[rtl/canopen_nmt_slave_fsm.sv]
// CANopen NMT slave state machine. Each transaction on evt_i is one event
// (power-on, received node-control frame, local command, boot-up transmit
// result) and yields exactly one transaction on res_o carrying the node state
// after the event, the boot-up request with its CAN identifier (0x700 plus
// node ID), the reset-pass flags and whether the event caused a transition.
// The block takes one event per clock cycle unless back-pressure on res_o
// holds it; an event passes the input register, then the result register,
// before its result is presented on res_o. The rate is set by the single
// state register, which the compute stage reads and updates in the same
// cycle as it loads the result register, so back to back events see each
// other's state. The node ID register (APB byte address 0, reset 1) should
// be written only while no event is in flight.
module canopen_nmt_slave_fsm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cnmt_evt_if.sink                      evt_i,
  cnmt_res_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cnmt_pkg::ApbAddrW-1:0] paddr,
  input  logic [cnmt_pkg::ApbDataW-1:0] pwdata,
  output logic [cnmt_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import cnmt_pkg::*;

  logic [NodeIdW-1:0] node_id;
  evt_stage_t         stage;
  logic               take;

  // Configuration registers
  cnmt_apb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .node_id_o (node_id)
  );

  // Event input register
  cnmt_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .evt_i   (evt_i),
    .take_i  (take),
    .stage_o (stage)
  );

  // State update and result register
  cnmt_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage),
    .node_id_i (node_id),
    .take_o    (take),
    .res_o     (res_o)
  );

endmodule

[sim/tb_canopen_nmt_slave_fsm.sv]
module tb_canopen_nmt_slave_fsm;
  import cnmt_pkg::*;

  localparam int unsigned IdleLimit = 500;
  localparam int unsigned SettleCyc = 8;
  localparam int unsigned PhaseLen  = 260;

  // Expected result of one event
  typedef struct packed {
    logic [StateW-1:0] node_state;
    logic              send_boot_up;
    logic [CanIdW-1:0] boot_up_id;
    logic              pass_app;
    logic              pass_comm;
    logic              handled;
  } nmt_res_t;

  // Optional hand-typed expectation that travels with a directed event
  typedef struct packed {
    bit       pin;
    nmt_res_t r;
  } pinned_t;

  typedef struct {
    evt_t     e;
    bit       pin;
    nmt_res_t r;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic pready;

  cnmt_evt_if evt_if ();
  cnmt_res_if res_if ();

  canopen_nmt_slave_fsm u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .evt_i   (evt_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the node state and the node ID register
  logic [StateW-1:0]  nmt_state_m;
  logic [NodeIdW-1:0] node_id_m;

  nmt_res_t  state_res_q[$];
  pinned_t   pin_q[$];
  dir_row_t  dir_q[$];

  bit          calm;
  int unsigned err_cnt;
  int unsigned res_cnt;
  int unsigned evt_cnt;
  int unsigned sent_cnt;
  int unsigned hdl_cnt;
  int unsigned boot_cnt;
  int unsigned id_cnt;
  int unsigned idle_cyc;
  nmt_res_t    want;
  nmt_res_t    pred;
  pinned_t     pinned;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_v);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, exp_v,
             res_cnt);
    err_cnt++;
  endtask

  // Next-state and result computation for one event
  function automatic nmt_res_t next_nmt_result(input evt_t e);
    logic [StateW-1:0] nxt;
    logic snd, app, comm, hdl, take, live;
    nmt_res_t r;
    nxt  = nmt_state_m;
    snd  = 1'b0;
    app  = 1'b0;
    comm = 1'b0;
    hdl  = 1'b0;
    live = (nmt_state_m >= StWait) && (nmt_state_m <= StStop);
    case (e.mode)
      ModePowerOn: begin
        nxt  = StWait;
        snd  = 1'b1;
        app  = 1'b1;
        comm = 1'b1;
        hdl  = 1'b1;
      end
      ModeTxDone: begin
        if (nmt_state_m == StWait && !e.tx_failed) begin
          nxt = StPreop;
          hdl = 1'b1;
        end
      end
      default: begin
        if (live) begin
          take = 1'b1;
          // frame filter: length and addressee
          if (e.mode == ModeFrame && (e.frame_length != FrameLenOk ||
              (e.target_node != AddrAll && e.target_node != {1'b0, node_id_m})))
            take = 1'b0;
          if (take) begin
            case (e.command)
              CmdRstNode: begin
                nxt  = StWait;
                snd  = 1'b1;
                app  = 1'b1;
                comm = 1'b1;
                hdl  = 1'b1;
              end
              CmdRstComm: begin
                nxt  = StWait;
                snd  = 1'b1;
                comm = 1'b1;
                hdl  = 1'b1;
              end
              CmdStart: begin
                if (nmt_state_m == StPreop || nmt_state_m == StStop) begin
                  nxt = StOper;
                  hdl = 1'b1;
                end
              end
              CmdStop: begin
                if (nmt_state_m == StPreop || nmt_state_m == StOper) begin
                  nxt = StStop;
                  hdl = 1'b1;
                end
              end
              CmdPreop: begin
                if (nmt_state_m == StOper || nmt_state_m == StStop) begin
                  nxt = StPreop;
                  hdl = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end
    endcase
    nmt_state_m    = nxt;
    r.node_state   = nxt;
    r.send_boot_up = snd;
    r.boot_up_id   = snd ? BootUpBase + CanIdW'(node_id_m) : '0;
    r.pass_app     = app;
    r.pass_comm    = comm;
    r.handled      = hdl;
    return r;
  endfunction

  function automatic nmt_res_t quiet_res(input logic [StateW-1:0] st);
    return nmt_res_t'{st, 1'b0, 11'd0, 1'b0, 1'b0, 1'b0};
  endfunction

  // Boot-up request with the reset node ID
  function automatic nmt_res_t boot_res(input logic app);
    return nmt_res_t'{StWait, 1'b1, BootUpBase + CanIdW'(NodeIdRst), app, 1'b1, 1'b1};
  endfunction

  task automatic add_row(input logic [ModeW-1:0] m, input logic [FrameLenW-1:0] l,
                         input logic [CmdW-1:0] c, input logic [TargetW-1:0] t,
                         input logic f, input bit pin, input nmt_res_t r);
    dir_row_t row;
    row.e   = evt_t'{m, l, c, t, f};
    row.pin = pin;
    row.r   = r;
    dir_q.push_back(row);
  endtask

  // Random event, mostly well-formed commands addressed to this node
  function automatic evt_t rand_evt();
    evt_t e;
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 10)      e.mode = ModePowerOn;
    else if (k < 45) e.mode = ModeFrame;
    else if (k < 75) e.mode = ModeLocal;
    else             e.mode = ModeTxDone;
    e.frame_length = ($urandom_range(0, 9) < 8) ? FrameLenOk : FrameLenW'($urandom_range(0, 15));
    if ($urandom_range(0, 9) < 8) begin
      case ($urandom_range(0, 4))
        0:       e.command = CmdStart;
        1:       e.command = CmdStop;
        2:       e.command = CmdPreop;
        3:       e.command = CmdRstNode;
        default: e.command = CmdRstComm;
      endcase
    end else begin
      e.command = CmdW'($urandom_range(0, 255));
    end
    k = $urandom_range(0, 9);
    if (k < 4)      e.target_node = AddrAll;
    else if (k < 8) e.target_node = {1'b0, node_id_m};
    else            e.target_node = TargetW'($urandom_range(0, 255));
    e.tx_failed = ($urandom_range(0, 3) == 0);
    return e;
  endfunction

  // Event source: random gap, then hold the transaction until accepted
  task automatic send_evt(input evt_t e, input bit pin, input nmt_res_t r);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      evt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pin_q.push_back(pinned_t'{pin, r});
    evt_if.valid        <= 1'b1;
    evt_if.mode         <= e.mode;
    evt_if.frame_length <= e.frame_length;
    evt_if.command      <= e.command;
    evt_if.target_node  <= e.target_node;
    evt_if.tx_failed    <= e.tx_failed;
    do @(posedge clk_i); while (!evt_if.ready);
    sent_cnt++;
  endtask

  // Wait until every sent transaction has its result back
  task automatic drain_results();
    evt_if.valid <= 1'b0;
    while (res_cnt < sent_cnt) @(posedge clk_i);
  endtask

  // APB write, then read back the node ID
  task automatic set_node_id(input logic [NodeIdW-1:0] id);
    logic [ApbDataW-1:0] d;
    d = ApbDataW'($urandom);
    d[NodeIdW-1:0] = id;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ApbAddrW'({RegNodeId, 2'b00});
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    node_id_m = id;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[NodeIdW-1:0] !== id)
      report_mismatch("node_id readback", prdata[NodeIdW-1:0], id);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    id_cnt++;
  endtask

  // Predict on every accepted event
  always @(posedge clk_i) begin
    if (rst_ni && evt_if.valid && evt_if.ready) begin
      pinned = pin_q.pop_front();
      pred = next_nmt_result(evt_t'{evt_if.mode, evt_if.frame_length, evt_if.command,
                                    evt_if.target_node, evt_if.tx_failed});
      state_res_q.push_back(pinned.pin ? pinned.r : pred);
      evt_cnt++;
    end
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      res_cnt++;
      if (state_res_q.size() == 0) begin
        report_mismatch("unexpected result, node_state", res_if.node_state, 0);
      end else begin
        want = state_res_q.pop_front();
        if (res_if.node_state !== want.node_state)
          report_mismatch("node_state", res_if.node_state, want.node_state);
        if (res_if.send_boot_up !== want.send_boot_up)
          report_mismatch("send_boot_up", res_if.send_boot_up, want.send_boot_up);
        if (res_if.boot_up_id !== want.boot_up_id)
          report_mismatch("boot_up_id", res_if.boot_up_id, want.boot_up_id);
        if (res_if.passed_reset_application !== want.pass_app)
          report_mismatch("passed_reset_application", res_if.passed_reset_application,
                          want.pass_app);
        if (res_if.passed_reset_communication !== want.pass_comm)
          report_mismatch("passed_reset_communication",
                          res_if.passed_reset_communication, want.pass_comm);
        if (res_if.handled !== want.handled)
          report_mismatch("handled", res_if.handled, want.handled);
        if (want.handled)      hdl_cnt++;
        if (want.send_boot_up) boot_cnt++;
      end
    end
  end

  // Result sink with random back-pressure
  initial begin
    int unsigned stall;
    res_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  // Watchdog: cycles without any transaction
  always @(posedge clk_i) begin
    if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready) || psel)
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
  end

  initial begin
    @(posedge clk_i);
    while (idle_cyc < IdleLimit) @(posedge clk_i);
    $display("Timeout: no transaction for %0d cycles", IdleLimit);
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus
  initial begin
    logic [NodeIdW-1:0] ids [5];
    dir_row_t row;
    evt_if.valid        <= 1'b0;
    evt_if.mode         <= ModePowerOn;
    evt_if.frame_length <= '0;
    evt_if.command      <= '0;
    evt_if.target_node  <= '0;
    evt_if.tx_failed    <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_ni  <= 1'b0;
    nmt_state_m = StOff;
    node_id_m   = NodeIdRst;
    err_cnt = 0;
    res_cnt = 0;
    evt_cnt = 0;
    sent_cnt = 0;
    hdl_cnt = 0;
    boot_cnt = 0;
    id_cnt = 0;
    calm = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: off state, boot-up handshake, filtering, every command
    add_row(ModeFrame,   2,  CmdStart,   0,   0, 1, quiet_res(StOff));
    add_row(ModeTxDone,  0,  0,          0,   0, 1, quiet_res(StOff));
    add_row(ModeLocal,   0,  CmdRstNode, 0,   0, 1, quiet_res(StOff));
    add_row(ModeFrame,   0,  CmdRstComm, 0,   0, 1, quiet_res(StOff));
    add_row(ModePowerOn, 0,  0,          0,   0, 1, boot_res(1'b1));
    add_row(ModeLocal,   0,  CmdStart,   0,   0, 1, quiet_res(StWait));
    add_row(ModeTxDone,  0,  0,          0,   1, 1, quiet_res(StWait));
    add_row(ModeFrame,   2,  CmdRstComm, 0,   0, 0, '0);
    add_row(ModeTxDone,  0,  0,          0,   0, 0, '0);
    add_row(ModeFrame,   3,  CmdStart,   0,   0, 1, quiet_res(StPreop));
    add_row(ModeFrame,   2,  CmdStart,   5,   0, 1, quiet_res(StPreop));
    add_row(ModeFrame,   2,  CmdStart,   1,   0, 0, '0);
    add_row(ModeLocal,   0,  CmdStart,   0,   0, 0, '0);
    add_row(ModeLocal,   0,  8'hFF,      0,   0, 1, quiet_res(StOper));
    add_row(ModeFrame,   2,  CmdStop,    0,   0, 0, '0);
    add_row(ModeLocal,   0,  CmdStop,    0,   0, 0, '0);
    add_row(ModeFrame,   2,  CmdPreop,   1,   0, 0, '0);
    add_row(ModeLocal,   0,  CmdPreop,   0,   0, 0, '0);
    add_row(ModeLocal,   0,  CmdStop,    0,   0, 0, '0);
    add_row(ModeLocal,   0,  CmdStart,   0,   0, 0, '0);
    add_row(ModeTxDone,  0,  0,          0,   0, 0, '0);
    add_row(ModeFrame,   2,  CmdRstNode, 0,   0, 0, '0);
    add_row(ModePowerOn, 15, 8'hFF,      255, 1, 1, boot_res(1'b1));
    add_row(ModeTxDone,  0,  0,          0,   0, 0, '0);
    add_row(ModeFrame,   15, 0,          255, 0, 1, quiet_res(StPreop));
    add_row(ModeLocal,   0,  CmdRstComm, 255, 1, 0, '0);
    while (dir_q.size() != 0) begin
      row = dir_q.pop_front();
      send_evt(row.e, row.pin, row.r);
    end

    // Random phases, one per node ID setting; the first keeps the reset ID
    ids[0] = 7'd127;
    ids[1] = 7'd0;
    ids[2] = NodeIdW'($urandom_range(1, 126));
    ids[3] = NodeIdW'($urandom_range(1, 126));
    ids[4] = NodeIdRst;
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        drain_results();
        repeat (4) @(posedge clk_i);
        set_node_id(ids[p-1]);
      end
      for (int i = 0; i < ((p == 0) ? PhaseLen - 30 : PhaseLen); i++) begin
        calm = (i < 30);
        // let the pipeline run dry once per phase
        if (i == PhaseLen / 2) drain_results();
        send_evt(rand_evt(), 1'b0, '0);
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (SettleCyc) @(posedge clk_i);
    if (state_res_q.size() != 0)
      report_mismatch("results still missing", 0, state_res_q.size());
    $display("Checked %0d events, %0d results: %0d transitions, %0d boot-up requests,",
             evt_cnt, res_cnt, hdl_cnt, boot_cnt);
    $display("over the reset node ID and %0d written settings (0, 1, 127, random)",
             id_cnt);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/cnmt_pkg.sv
rtl/cnmt_if.sv
rtl/cnmt_apb_regs.sv
rtl/cnmt_in_stage.sv
rtl/cnmt_core.sv
rtl/canopen_nmt_slave_fsm.sv
sim/tb_canopen_nmt_slave_fsm.sv
